// File: sv/assert_macros.svh
// assertion macros shared by the run-length line map modules
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define RLLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define RLLM_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/rllm_pkg.sv
// shared types and constants for the run-length line map
// no dependencies
package rllm_pkg;

    localparam int MAX_RUNS_DEF = 256;

    localparam int LINE_W   = 32;
    localparam int POS_W    = 32;
    localparam int LEN_W    = 8;
    localparam int BOUND_W  = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = LINE_W + 2 * BOUND_W;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        RES_ADD,
        RES_HIT,
        RES_NOMAP
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     add_exec;
        logic     issue;
        logic     pend_load;
        res_sel_t pend_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic req_lookup;
        logic count_zero;
        logic issue_done;
        logic chk_valid;
        logic chk_last;
        logic hit;
    } dp_sts_t;

endpackage

// File: sv/rllm_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rllm_datapath.sv
// datapath: request capture, last-run registers, run table, scan compare, result registers
// depends on rllm_pkg, rllm_ram and assert_macros.svh
`include "assert_macros.svh"

module rllm_datapath #(
    parameter int MAX_RUNS = rllm_pkg::MAX_RUNS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_type,
    input  logic [rllm_pkg::LEN_W-1:0]    run_length,
    input  logic [rllm_pkg::LINE_W-1:0]   line_number,
    input  logic [rllm_pkg::POS_W-1:0]    byte_position,
    output logic [rllm_pkg::LINE_W-1:0]   found_line,
    output logic [rllm_pkg::STATUS_W-1:0] status,
    input  rllm_pkg::dp_cmd_t             cmd,
    output rllm_pkg::dp_sts_t             sts
);

    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int LW = rllm_pkg::LINE_W;
    localparam int BW = rllm_pkg::BOUND_W;
    localparam int EW = rllm_pkg::ENTRY_W;
    localparam int PW = rllm_pkg::POS_W;

    // captured request
    logic [LW-1:0]                  line_in_reg;
    logic [rllm_pkg::LEN_W-1:0]     len_reg;
    logic [PW-1:0]                  pos_reg;

    // table bookkeeping
    logic [CW-1:0]                  count_reg, count_next;
    logic [LW-1:0]                  last_line_reg;
    logic [BW-1:0]                  last_start_reg, last_end_reg;

    // scan pipeline
    logic [CW-1:0]                  idx_reg;
    logic                           chk_valid_reg, chk_last_reg;

    // pending and output results
    logic [LW-1:0]                  pend_line_reg, pend_line_next;
    logic [rllm_pkg::STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [LW-1:0]                  out_line_reg;
    logic [rllm_pkg::STATUS_W-1:0]  out_status_reg;

    logic [CW-1:0] cnt_m1;
    logic          count_zero, merge, full;
    logic [BW-1:0] len_ext, base, start_new, end_new;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic [LW-1:0] rd_line;
    logic [BW-1:0] rd_start, rd_end, pos_lo;
    logic          hit;

    assign cnt_m1     = count_reg - CW'(1);
    assign count_zero = (count_reg == '0);
    assign merge      = !count_zero && (last_line_reg == line_in_reg);
    assign full       = !merge && (count_reg == CW'(MAX_RUNS));
    assign len_ext    = {{(BW - rllm_pkg::LEN_W){1'b0}}, len_reg};
    assign base       = count_zero ? '0 : last_end_reg;
    assign start_new  = merge ? last_start_reg : base;
    // end wraps modulo 2^16
    assign end_new    = (merge ? last_end_reg : base) + len_ext;
    assign wr_en      = cmd.add_exec && !full;
    assign wr_addr    = merge ? cnt_m1[AW-1:0] : count_reg[AW-1:0];
    assign wr_data    = {line_in_reg, start_new, end_new};
    assign count_next = (wr_en && !merge) ? count_reg + CW'(1) : count_reg;

    rllm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_RUNS)
    ) u_run_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.issue),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_line  = rd_data[EW-1 -: LW];
    assign rd_start = rd_data[2*BW-1 -: BW];
    assign rd_end   = rd_data[BW-1:0];
    assign pos_lo   = pos_reg[BW-1:0];
    // positions at or above 2^16 never fall inside a run
    assign hit      = (pos_reg[PW-1:BW] == '0) && (rd_start <= pos_lo) && (pos_lo < rd_end);

    always_comb
    begin
        case (cmd.pend_sel)
            rllm_pkg::RES_ADD:
            begin
                pend_line_next   = '0;
                pend_status_next = full ? rllm_pkg::ST_FULL : rllm_pkg::ST_DONE;
            end
            rllm_pkg::RES_HIT:
            begin
                pend_line_next   = rd_line;
                pend_status_next = rllm_pkg::ST_DONE;
            end
            default:
            begin
                pend_line_next   = '0;
                pend_status_next = rllm_pkg::ST_NOMAP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            chk_valid_reg <= cmd.issue;
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg      <= idx_reg + CW'(1);
                chk_last_reg <= (idx_reg == cnt_m1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            line_in_reg <= line_number;
            len_reg     <= run_length;
            pos_reg     <= byte_position;
        end
        if (wr_en)
        begin
            last_line_reg  <= line_in_reg;
            last_start_reg <= start_new;
            last_end_reg   <= end_new;
        end
        if (cmd.pend_load)
        begin
            pend_line_reg   <= pend_line_next;
            pend_status_reg <= pend_status_next;
        end
        if (cmd.out_load)
        begin
            out_line_reg   <= pend_line_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign found_line = out_line_reg;
    assign status     = out_status_reg;

    assign sts.req_lookup = (req_type == rllm_pkg::REQ_LOOKUP);
    assign sts.count_zero = count_zero;
    assign sts.issue_done = (idx_reg == count_reg);
    assign sts.chk_valid  = chk_valid_reg;
    assign sts.chk_last   = chk_last_reg;
    assign sts.hit        = hit;

    `RLLM_NEVER(a_count_range, count_reg > CW'(MAX_RUNS), "run count above capacity")
    `RLLM_ASSERT(a_full_hold, (cmd.add_exec && full) |=> (count_reg == CW'(MAX_RUNS)), "dropped add changed the run count")

endmodule

// File: sv/rllm_ctrl.sv
// controller: sequences add, scan and result hand-off, owns the output valid
// depends on rllm_pkg and assert_macros.svh
`include "assert_macros.svh"

module rllm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rllm_pkg::dp_cmd_t cmd,
    input  rllm_pkg::dp_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.pend_sel = rllm_pkg::RES_NOMAP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!sts.req_lookup)
                    begin
                        state_next = S_ADD;
                    end
                    else if (sts.count_zero)
                    begin
                        // empty table: answer right away
                        cmd.pend_load = 1'b1;
                        cmd.pend_sel  = rllm_pkg::RES_NOMAP;
                        state_next    = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_ADD:
            begin
                cmd.add_exec  = 1'b1;
                cmd.pend_load = 1'b1;
                cmd.pend_sel  = rllm_pkg::RES_ADD;
                state_next    = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.issue = !sts.issue_done;
                if (sts.chk_valid && sts.hit)
                begin
                    cmd.pend_load = 1'b1;
                    cmd.pend_sel  = rllm_pkg::RES_HIT;
                    state_next    = S_RESULT;
                end
                else if (sts.chk_valid && sts.chk_last)
                begin
                    cmd.pend_load = 1'b1;
                    cmd.pend_sel  = rllm_pkg::RES_NOMAP;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `RLLM_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_reg || out_ready), "output beat overwritten before taken")
    `RLLM_ASSERT(a_scan_nonempty, (state_reg == S_SCAN) |-> !sts.count_zero, "scan started on an empty table")

endmodule

// File: sv/run_length_line_map.sv
// top level of the run-length line map: byte range to source line table
// depends on rllm_pkg, rllm_ctrl, rllm_datapath (and through it rllm_ram)
//
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_ready   req_type, run_length, line_number, byte_position
//  out      from block out_valid / out_ready found_line, status
//
// an add goes through capture, table update and hand-off before its output beat is loaded
// a lookup scans the runs in order and answers the first match, or no mapping after the last run;
//   an empty table is answered without a scan; the ram's single read port scans one run a cycle
// reset clears the run count, not the table; table entries are never read before they are written
// a finished beat waits in the output register while the next request is already accepted;
//   a second result stalls in the hand-off state until the output register is free
module run_length_line_map #(
    parameter int MAX_RUNS = rllm_pkg::MAX_RUNS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [rllm_pkg::LEN_W-1:0]    run_length,
    input  logic [rllm_pkg::LINE_W-1:0]   line_number,
    input  logic [rllm_pkg::POS_W-1:0]    byte_position,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rllm_pkg::LINE_W-1:0]   found_line,
    output logic [rllm_pkg::STATUS_W-1:0] status
);

    // command and status between controller and datapath
    rllm_pkg::dp_cmd_t cmd;
    rllm_pkg::dp_sts_t sts;

    // sequencing: idle, add, scan, result hand-off
    rllm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // run table, last-run shadow registers, scan compare and result registers
    rllm_datapath #(
        .MAX_RUNS (MAX_RUNS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req_type),
        .run_length    (run_length),
        .line_number   (line_number),
        .byte_position (byte_position),
        .found_line    (found_line),
        .status        (status),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// File: test/run_length_line_map_checker.sv
`timescale 1ns / 100ps
// result checker for run_length_line_map: keeps its own copy of the run table
// depends on rllm_pkg for widths, request kinds and status codes
module run_length_line_map_checker #(
    parameter int MAX_RUNS = rllm_pkg::MAX_RUNS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          req_type,
    input  logic [rllm_pkg::LEN_W-1:0]    run_length,
    input  logic [rllm_pkg::LINE_W-1:0]   line_number,
    input  logic [rllm_pkg::POS_W-1:0]    byte_position,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [rllm_pkg::LINE_W-1:0]   found_line,
    input  logic [rllm_pkg::STATUS_W-1:0] status,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [rllm_pkg::LINE_W-1:0]   line;
        logic [rllm_pkg::STATUS_W-1:0] code;
    } answer_t;

    // shadow run table
    logic [rllm_pkg::LINE_W-1:0]  run_owner [MAX_RUNS];
    logic [rllm_pkg::BOUND_W-1:0] run_first [MAX_RUNS];
    logic [rllm_pkg::BOUND_W-1:0] run_limit [MAX_RUNS];
    int unsigned                  runs_held = 0;

    answer_t answer_q [$];
    int      fails = 0;
    int      owed = 0;

    assign fail_count = fails;
    assign pending    = owed;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("line map mismatch at %0t: %s got %h want %h", $time, what, got, want);
        fails++;
    endtask

    // updates the shadow table and returns the answer the block owes
    function automatic answer_t map_request(input logic req,
                                            input logic [rllm_pkg::LEN_W-1:0] len,
                                            input logic [rllm_pkg::LINE_W-1:0] line,
                                            input logic [rllm_pkg::POS_W-1:0] pos);
        answer_t                      ans;
        logic                         hit;
        logic [rllm_pkg::BOUND_W-1:0] base;
        ans.line = '0;
        ans.code = rllm_pkg::ST_DONE;
        hit      = 1'b0;
        if (req == rllm_pkg::REQ_ADD)
        begin
            if (runs_held > 0 && run_owner[runs_held-1] == line)
                run_limit[runs_held-1] = run_limit[runs_held-1] + len;
            else if (runs_held >= MAX_RUNS)
                ans.code = rllm_pkg::ST_FULL;
            else
            begin
                base = '0;
                if (runs_held > 0)
                    base = run_limit[runs_held-1];
                run_owner[runs_held] = line;
                run_first[runs_held] = base;
                run_limit[runs_held] = base + len;
                runs_held++;
            end
        end
        else
        begin
            ans.code = rllm_pkg::ST_NOMAP;
            for (int unsigned k = 0; k < runs_held; k++)
            begin
                if (!hit && {16'b0, run_first[k]} <= pos && pos < {16'b0, run_limit[k]})
                begin
                    hit      = 1'b1;
                    ans.line = run_owner[k];
                    ans.code = rllm_pkg::ST_DONE;
                end
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            runs_held = 0;
            answer_q.delete();
            owed = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                    report("result beat with nothing owed, found_line", found_line, '0);
                else
                begin
                    want = answer_q.pop_front();
                    if (found_line !== want.line)
                        report("found_line", found_line, want.line);
                    if (status !== want.code)
                        report("status", status, want.code);
                end
            end
            if (in_valid && in_ready)
                answer_q.insert(answer_q.size(),
                                map_request(req_type, run_length, line_number, byte_position));
            owed = answer_q.size();
        end
    end

endmodule

// File: test/run_length_line_map_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for run_length_line_map: directed corner beats, then four idling phases
// depends on rllm_pkg, run_length_line_map and run_length_line_map_checker
module run_length_line_map_test;

    // worst item is a full-table lookup plus long idle and stall
    // stretches; the limit is several times the slowest plausible run of ~525 beats
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_BEATS   = 125;
    localparam int SETTLE_CYCLES = rllm_pkg::MAX_RUNS_DEF + 16;
    localparam int LEN_BITS      = rllm_pkg::LEN_W;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          req_type = rllm_pkg::REQ_ADD;
    logic [rllm_pkg::LEN_W-1:0]    run_length = '0;
    logic [rllm_pkg::LINE_W-1:0]   line_number = '0;
    logic [rllm_pkg::POS_W-1:0]    byte_position = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [rllm_pkg::LINE_W-1:0]   found_line;
    logic [rllm_pkg::STATUS_W-1:0] status;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // idling per phase, in percent: none, sender idle, receiver stall, both
    int phase_idle  [4] = '{0, 77, 0, 20};
    int phase_stall [4] = '{0, 0, 77, 20};
    int send_idle_pct = 0;
    int stall_pct = 0;

    // rough view of the table, only used to aim lookups and line choices
    int unsigned                  runs_used = 0;
    logic [rllm_pkg::LINE_W-1:0]  tail_line = '0;
    logic [rllm_pkg::BOUND_W-1:0] tail_end = '0;
    int unsigned                  bytes_added = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    run_length_line_map uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .run_length    (run_length),
        .line_number   (line_number),
        .byte_position (byte_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found_line    (found_line),
        .status        (status)
    );

    run_length_line_map_checker line_map_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .run_length    (run_length),
        .line_number   (line_number),
        .byte_position (byte_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found_line    (found_line),
        .status        (status),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // receiver: stalls at random, at the rate of the current phase
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run_length_line_map_test failed");
            $finish;
        end
    end

    // one request beat; entered and left at a falling edge, valid left high on exit so a
    // back-to-back beat just swaps the payload
    task automatic send_beat(input logic req, input logic [rllm_pkg::LEN_W-1:0] len,
                             input logic [rllm_pkg::LINE_W-1:0] line,
                             input logic [rllm_pkg::POS_W-1:0] pos);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        run_length    <= len;
        line_number   <= line;
        byte_position <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        // follow the table roughly: a dropped add changes nothing
        if (req == rllm_pkg::REQ_ADD &&
            ((runs_used > 0 && line == tail_line) || runs_used < rllm_pkg::MAX_RUNS_DEF))
        begin
            if (!(runs_used > 0 && line == tail_line))
                runs_used++;
            tail_line   = line;
            tail_end    = tail_end + len;
            bytes_added = bytes_added + len;
        end
    endtask

    // sender holds off until every owed result has come back
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // random beat: add-heavy with mostly long runs so the 16-bit ends wrap and the
    // table fills up within the run; after that, new lines are dropped and only
    // merges onto the last run go through
    task automatic send_random;
        int unsigned                 pick;
        int unsigned                 span;
        logic [rllm_pkg::LEN_W-1:0]  len;
        logic [rllm_pkg::LINE_W-1:0] line;
        logic [rllm_pkg::POS_W-1:0]  pos;
        len  = ($urandom_range(0, 99) < 85) ? LEN_BITS'($urandom_range(240, 255))
                                            : LEN_BITS'($urandom_range(0, 255));
        line = $urandom;
        pos  = $urandom;
        if ($urandom_range(0, 99) < 72)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                line = tail_line;               // merge onto the last run
            else if (pick < 25)
                line = $urandom_range(0, 3);    // lines that repeat but not adjacently
            send_beat(rllm_pkg::REQ_ADD, len, line, pos);
        end
        else
        begin
            span = (bytes_added > 65535) ? 65535 : bytes_added;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                pos = $urandom_range(0, span);
            else if (pick < 80)
                pos = {16'b0, tail_end} + $urandom_range(0, 2) - 1;   // around the open end
            else if (pick < 90)
                pos = 32'h0000_FFFF + $urandom_range(0, 1);           // top of the 16-bit range
            send_beat(rllm_pkg::REQ_LOOKUP, len, line, pos);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: nothing maps
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, '0);
        send_beat(rllm_pkg::REQ_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero-length first run matches nothing
        send_beat(rllm_pkg::REQ_ADD, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'd0);
        // longest run, then a merge onto it with the same line
        send_beat(rllm_pkg::REQ_ADD, 8'd255, 32'hFFFF_FFFF, '0);
        send_beat(rllm_pkg::REQ_ADD, 8'd255, 32'hFFFF_FFFF, '0);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'd0);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'd509);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'd510);
        // line 0 again, not adjacent: new run, and a hit that answers line zero
        send_beat(rllm_pkg::REQ_ADD, 8'd1, 32'd0, '0);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'd510);
        send_beat(rllm_pkg::REQ_ADD, 8'd0, 32'd0, '0);
        send_beat(rllm_pkg::REQ_ADD, 8'd128, 32'h8000_0000, '0);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'd638);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'd639);
        // positions past 16 bits never match; 16'hFFFF lies past every run here
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'h0001_0005);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'h8000_0000);
        send_beat(rllm_pkg::REQ_LOOKUP, '0, '0, 32'h0000_FFFF);
        send_beat(rllm_pkg::REQ_ADD, 8'd127, 32'h5555_5555, 32'hAAAA_AAAA);
        send_beat(rllm_pkg::REQ_ADD, 8'd200, 32'hAAAA_AAAA, 32'h5555_5555);
        send_beat(rllm_pkg::REQ_LOOKUP, 8'hAA, 32'h1234_5678, 32'd639);
        send_beat(rllm_pkg::REQ_LOOKUP, 8'h55, 32'h8765_4321, 32'd766);
        drain();

        // random phases, each ending with a full drain
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = phase_idle[phase];
            stall_pct     = phase_stall[phase];
            for (int n = 0; n < PHASE_BEATS; n++)
                send_random();
            drain();
        end

        // let any stray beat show up before the verdict
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("run_length_line_map_test passed");
        else
            $display("run_length_line_map_test failed");
        $finish;
    end

endmodule
